### hdl/assert_macros.svh
// Assertion helpers; the using module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// Invariant, checked out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant failed");

`endif

### hdl/gdfo_pkg.sv
`default_nettype none

package gdfo_pkg;

  localparam int NODES_DEFAULT = 8;

  localparam int FUNC_W = 2;
  localparam int NODE_W = 3;

  // Only vertices below this bound can ever carry an edge.
  localparam int EDGE_SPAN = 1 << NODE_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD_EDGE = 2'd0,
    FUNC_CLEAR    = 2'd1,
    FUNC_SEARCH   = 2'd2,
    FUNC_NOP      = 2'd3
  } func_t;

endpackage

`default_nettype wire

### hdl/graph_depth_first_order.sv
// Depth-first ordering engine over an undirected adjacency bit matrix.
// Input channel (in_valid/in_stall): one transaction carries in_func plus
// in_node_a, in_node_b and in_start_node. Add edge sets both matrix bits
// (ignored when an endpoint is out of range); clear wipes all edges. Both
// return nothing. Search emits every vertex exactly once on the output
// channel (out_valid/out_stall), out_last on the final one.
// A search walks a vertex stack, one step per cycle through a single
// priority picker: push the smallest unvisited neighbor of the top, or pop,
// or (stack empty) advance a restart pointer one vertex per cycle. in_stall
// stays high for the whole search; a new transaction is taken once the last
// result is loaded into the output register. out_valid is registered.
// When the receiver stalls the output register holds and the next visit
// waits until it frees; pops and the restart scan go on meanwhile. Reset
// (rst_n low, synchronous) clears the matrix, the visited mask, the stack
// depth and out_valid; no clearing sequence follows.
`default_nettype none

module graph_depth_first_order #(
  parameter int NODES = gdfo_pkg::NODES_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gdfo_pkg::FUNC_W-1:0] in_func,
  input  wire logic [gdfo_pkg::NODE_W-1:0] in_node_a,
  input  wire logic [gdfo_pkg::NODE_W-1:0] in_node_b,
  input  wire logic [gdfo_pkg::NODE_W-1:0] in_start_node,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [gdfo_pkg::NODE_W-1:0]      out_visited_node,
  output logic                             out_last
);

  `include "assert_macros.svh"

  localparam int ROWS    = (NODES < gdfo_pkg::EDGE_SPAN) ? NODES : gdfo_pkg::EDGE_SPAN;
  localparam int IDX_W   = $clog2(NODES);
  localparam int RIDX_W  = $clog2(ROWS);
  localparam int DEPTH_W = $clog2(ROWS + 1);
  localparam int CNT_W   = $clog2(NODES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_STEP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [ROWS-1:0]         rows_r [ROWS];
  logic [ROWS-1:0]         rows_nxt [ROWS];
  logic [NODES-1:0]        visited_r, visited_nxt;
  logic [DEPTH_W-1:0]      depth_r, depth_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        scan_r, scan_nxt;
  logic [IDX_W-1:0]        start_r, start_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [gdfo_pkg::NODE_W-1:0] out_node_r, out_node_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [RIDX_W-1:0]       stack_r [ROWS];

  logic                    slot_free;
  logic [RIDX_W-1:0]       top_idx;
  logic [ROWS-1:0]         nb;
  logic [RIDX_W-1:0]       nb_lo;
  logic                    visit_en;
  logic [IDX_W-1:0]        visit_v;
  logic                    visit_last;
  logic                    push_en;

  assign slot_free = !out_valid_r || !out_stall;
  assign top_idx   = RIDX_W'(depth_r - DEPTH_W'(1));
  assign nb        = rows_r[stack_r[top_idx]] & ~visited_r[ROWS-1:0];

  // Smallest unvisited neighbor of the stack top.
  always_comb begin
    nb_lo = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (nb[i]) begin
        nb_lo = RIDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    visited_nxt   = visited_r;
    depth_nxt     = depth_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_node_nxt  = out_node_r;
    out_last_nxt  = out_last_r;
    visit_en      = 1'b0;
    visit_v       = '0;
    visit_last    = 1'b0;
    push_en       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (gdfo_pkg::func_t'(in_func))
            gdfo_pkg::FUNC_ADD_EDGE: begin
              if (int'(in_node_a) < NODES && int'(in_node_b) < NODES) begin
                rows_nxt[in_node_a[RIDX_W-1:0]][in_node_b[RIDX_W-1:0]] = 1'b1;
                rows_nxt[in_node_b[RIDX_W-1:0]][in_node_a[RIDX_W-1:0]] = 1'b1;
              end
            end
            gdfo_pkg::FUNC_CLEAR: begin
              for (int i = 0; i < ROWS; i++) begin
                rows_nxt[i] = '0;
              end
            end
            gdfo_pkg::FUNC_SEARCH: begin
              visited_nxt = '0;
              depth_nxt   = '0;
              count_nxt   = '0;
              scan_nxt    = '0;
              start_nxt   = IDX_W'(in_start_node);
              state_nxt   = (int'(in_start_node) < NODES) ? S_START : S_STEP;
            end
            default: begin
            end
          endcase
        end
      end
      S_START: begin
        if (slot_free) begin
          visit_en = 1'b1;
          visit_v  = start_r;
        end
      end
      S_STEP: begin
        if (depth_r == '0) begin
          // Stack empty: restart at the smallest unvisited vertex.
          if (visited_r[scan_r]) begin
            scan_nxt = IDX_W'(scan_r + 1'b1);
          end else if (slot_free) begin
            visit_en = 1'b1;
            visit_v  = scan_r;
          end
        end else if (nb != '0) begin
          if (slot_free) begin
            visit_en = 1'b1;
            visit_v  = IDX_W'(nb_lo);
          end
        end else begin
          depth_nxt = depth_r - DEPTH_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (visit_en) begin
      visit_last           = (count_r == CNT_W'(NODES - 1));
      visited_nxt[visit_v] = 1'b1;
      out_valid_nxt        = 1'b1;
      out_node_nxt         = gdfo_pkg::NODE_W'(visit_v);
      out_last_nxt         = visit_last;
      count_nxt            = count_r + CNT_W'(1);
      // Vertices without a matrix row have no neighbors; skip the push.
      if (int'(visit_v) < ROWS) begin
        push_en   = 1'b1;
        depth_nxt = depth_r + DEPTH_W'(1);
      end
      state_nxt = visit_last ? S_IDLE : S_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int i = 0; i < ROWS; i++) begin
        rows_r[i] <= '0;
      end
      visited_r   <= '0;
      depth_r     <= '0;
      count_r     <= '0;
      scan_r      <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      visited_r   <= visited_nxt;
      depth_r     <= depth_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_node_r <= out_node_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_r[depth_r[RIDX_W-1:0]] <= visit_v[RIDX_W-1:0];
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_visited_node = out_node_r;
  assign out_last         = out_last_r;

  `ASSERT_ALWAYS(a_depth_bound, depth_r <= DEPTH_W'(ROWS))
  `ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(NODES))
  `ASSERT_IMPLIES(a_visit_fresh, visit_en, !visited_r[visit_v])
  `ASSERT_IMPLIES(a_visit_slot, visit_en, slot_free)
  `ASSERT_NEXT(a_last_to_idle, visit_en && visit_last, state_r == S_IDLE && out_last_r)

endmodule

`default_nettype wire
